FILE: design/xtea_pkg.sv
`timescale 1ns / 1ps

package xtea_pkg;

  // Round constant and default round count
  localparam logic [31:0] DELTA      = 32'h9E3779B9;
  localparam int          ROUNDS_DEF = 32;

  // Configuration port
  localparam int CFG_IDX_W = 8;
  localparam int KEY_WORDS = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_WORD0 = 8'd0,
    REG_KEY_WORD1 = 8'd1,
    REG_KEY_WORD2 = 8'd2,
    REG_KEY_WORD3 = 8'd3
  } cfg_reg_t;

  typedef logic [KEY_WORDS-1:0][31:0] key_t;

  typedef struct packed {
    logic        func;
    logic [31:0] block_left;
    logic [31:0] block_right;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] result_left;
    logic [31:0] result_right;
  } out_beat_t;

  // Word carried from cell to cell
  typedef struct packed {
    logic        func;
    logic [31:0] y;
    logic [31:0] z;
  } stage_t;

  // Running sum after n deltas, modulo 2^32
  function automatic logic [31:0] sum_at(int n);
    logic [31:0] k;
    k      = 32'(n);
    sum_at = DELTA * k;
  endfunction

endpackage

FILE: design/xtea_cell.sv
`timescale 1ns / 1ps

// One half-round of XTEA. The sums for both directions are fixed per cell.
module xtea_cell #(
  parameter bit          HALF    = 1'b0,
  parameter logic [31:0] ENC_SUM = 32'd0,
  parameter logic [31:0] DEC_SUM = 32'd0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            prev_valid,
  input  xtea_pkg::stage_t prev,
  input  xtea_pkg::key_t  key,
  output logic            valid,
  output xtea_pkg::stage_t data
);

  // Key word index for each direction at this position
  localparam logic [1:0] ENC_KIDX = (HALF == 1'b0) ? ENC_SUM[1:0] : ENC_SUM[12:11];
  localparam logic [1:0] DEC_KIDX = (HALF == 1'b1) ? DEC_SUM[1:0] : DEC_SUM[12:11];

  logic             update_y;
  logic [31:0]      x;
  logic [31:0]      tgt;
  logic [31:0]      sum;
  logic [1:0]       kidx;
  logic [31:0]      mix;
  logic [31:0]      upd;
  xtea_pkg::stage_t data_next;

  // Mix one half into the other
  always_comb begin
    update_y  = (HALF == prev.func);
    x         = update_y ? prev.z : prev.y;
    tgt       = update_y ? prev.y : prev.z;
    sum       = prev.func ? DEC_SUM : ENC_SUM;
    kidx      = prev.func ? DEC_KIDX : ENC_KIDX;
    mix       = (((x << 4) ^ (x >> 5)) + x) ^ (sum + key[kidx]);
    upd       = prev.func ? (tgt - mix) : (tgt + mix);
    data_next = prev;
    if (update_y) begin
      data_next.y = upd;
    end else begin
      data_next.z = upd;
    end
  end

  // Advance the beat when the pipe moves
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data <= data_next;
    end
  end

endmodule

FILE: design/xtea_skid.sv
`timescale 1ns / 1ps

// Output skid stage: parks the last cell's beat when the receiver stalls.
module xtea_skid (
  input  logic               clk,
  input  logic               rst,
  input  logic               last_valid,
  input  xtea_pkg::stage_t   last,
  input  logic               out_ready,
  output logic               en,
  output logic               out_valid,
  output xtea_pkg::out_beat_t out_data
);

  logic                skid_valid;
  xtea_pkg::out_beat_t skid;
  xtea_pkg::out_beat_t last_beat;

  assign last_beat.result_left  = last.y;
  assign last_beat.result_right = last.z;

  // Pipe moves only while the skid slot is free
  assign en        = ~skid_valid;
  assign out_valid = skid_valid | last_valid;
  assign out_data  = skid_valid ? skid : last_beat;

  // Hold a stalled beat; drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) begin
        skid_valid <= 1'b0;
      end
    end else if (last_valid && !out_ready) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid && last_valid && !out_ready) begin
      skid <= last_beat;
    end
  end

endmodule

FILE: design/xtea_block_cipher_unit.sv
`timescale 1ns / 1ps

// XTEA block cipher, one 64-bit block per beat.
// Input channel (in_valid/in_ready/in_data): func selects encrypt (0) or
// decrypt (1); block_left and block_right are the two halves of the block.
// Output channel (out_valid/out_ready/out_data): the transformed halves, in
// the order the blocks were taken.
// Config channel (cfg_valid/cfg_ready/cfg_data/cfg_index): indexes 0..3 write
// key words 0..3; other indexes are ignored. cfg_ready is always high. Write
// the key only while no block is in flight.
// Each accepted block is registered once in every cell along the chain, one
// cell per half-round, and the last cell feeds the output channel.
// Throughput: one block per cycle while the output is not stalled, set by
// the chain of half-round cells that all advance together.
// When the receiver stalls, the finished beat moves to a skid register and
// one more input beat is taken; then in_ready drops until the skid drains.
// Reset clears all valid flags and the key words to zero.
module xtea_block_cipher_unit #(
  parameter int ROUNDS = xtea_pkg::ROUNDS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  xtea_pkg::in_beat_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output xtea_pkg::out_beat_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [xtea_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                       cfg_data
);

  localparam int STAGES = 2 * ROUNDS;

  xtea_pkg::key_t   key;
  logic             en;
  logic [STAGES:0]  vld;
  xtea_pkg::stage_t pipe [STAGES+1];

  // Key registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_valid) begin
      case (xtea_pkg::cfg_reg_t'(cfg_index))
        xtea_pkg::REG_KEY_WORD0: key[0] <= cfg_data;
        xtea_pkg::REG_KEY_WORD1: key[1] <= cfg_data;
        xtea_pkg::REG_KEY_WORD2: key[2] <= cfg_data;
        xtea_pkg::REG_KEY_WORD3: key[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Feed the first cell
  assign in_ready     = en;
  assign vld[0]       = in_valid;
  assign pipe[0].func = in_data.func;
  assign pipe[0].y    = in_data.block_left;
  assign pipe[0].z    = in_data.block_right;

  // Chain of half-round cells
  for (genvar s = 0; s < STAGES; s++) begin : g_cell
    localparam int RND = s / 2;
    localparam int HI  = s % 2;

    xtea_cell #(
      .HALF    (HI == 1),
      .ENC_SUM (xtea_pkg::sum_at(RND + HI)),
      .DEC_SUM (xtea_pkg::sum_at(ROUNDS - RND - HI))
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .prev_valid (vld[s]),
      .prev       (pipe[s]),
      .key        (key),
      .valid      (vld[s+1]),
      .data       (pipe[s+1])
    );
  end

  xtea_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .last_valid (vld[STAGES]),
    .last       (pipe[STAGES]),
    .out_ready  (out_ready),
    .en         (en),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

endmodule

FILE: design/xtea_checker.sv
`timescale 1ns / 1ps

module xtea_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input xtea_pkg::out_beat_t            out_data,
  input logic                           cfg_ready
);

  // No result beat right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high right after reset");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

  // Input backpressure only follows an output stall
  a_in_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> $past(out_valid && !out_ready))
    else $error("in_ready low without output stall");

  // Input ready returns once the stalled beat is taken
  a_in_recover: assert property (@(posedge clk) disable iff (rst)
    !in_ready && out_ready |=> in_ready)
    else $error("in_ready stuck after output drained");

  // Key writes never wait
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("cfg_ready low");

endmodule

bind xtea_block_cipher_unit xtea_checker u_xtea_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .cfg_ready (cfg_ready)
);

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int          ROUNDS          = xtea_pkg::ROUNDS_DEF;
  localparam int          LATENCY         = 2 * ROUNDS;
  localparam int          IDX_W           = xtea_pkg::CFG_IDX_W;
  localparam int          KEY_WORDS       = xtea_pkg::KEY_WORDS;
  localparam logic        FUNC_ENC        = 1'b0;
  localparam logic        FUNC_DEC        = 1'b1;
  localparam int          NUM_PHASES      = 6;
  localparam int          ITEMS_PER_PHASE = 100;
  localparam int          PRESSURE_AT     = 250;
  localparam int          PRESSURE_HOLD   = 300;
  localparam int          IDX_MAX         = (1 << IDX_W) - 1;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  xtea_pkg::in_beat_t   in_data;
  logic                 out_valid;
  logic                 out_ready;
  xtea_pkg::out_beat_t  out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [IDX_W-1:0]     cfg_index;
  logic [31:0]          cfg_data;

  // Key as the block should hold it, and results still owed by the block
  xtea_pkg::key_t      cur_key;
  xtea_pkg::out_beat_t pending_results[$];

  int errors        = 0;
  int results_seen  = 0;
  int enc_blocks    = 0;
  int dec_blocks    = 0;
  int key_settings  = 0;
  bit calm          = 1'b0;
  bit pressure_done = 1'b0;

  xtea_pkg::cfg_reg_t key_regs[KEY_WORDS] = '{xtea_pkg::REG_KEY_WORD0,
                                              xtea_pkg::REG_KEY_WORD1,
                                              xtea_pkg::REG_KEY_WORD2,
                                              xtea_pkg::REG_KEY_WORD3};

  // Directed blocks, all run under the reset (all-zero) key
  xtea_pkg::in_beat_t directed_rows[] = '{
    '{FUNC_ENC, 32'h00000000, 32'h00000000},
    '{FUNC_DEC, 32'h00000000, 32'h00000000},
    '{FUNC_ENC, 32'hFFFFFFFF, 32'hFFFFFFFF},
    '{FUNC_DEC, 32'hFFFFFFFF, 32'hFFFFFFFF},
    '{FUNC_ENC, 32'h00000000, 32'hFFFFFFFF},
    '{FUNC_ENC, 32'hFFFFFFFF, 32'h00000000},
    '{FUNC_DEC, 32'h00000000, 32'hFFFFFFFF},
    '{FUNC_DEC, 32'hFFFFFFFF, 32'h00000000},
    '{FUNC_ENC, 32'h80000000, 32'h00000001},
    '{FUNC_ENC, 32'h00000001, 32'h80000000},
    '{FUNC_ENC, 32'hAAAAAAAA, 32'h55555555},
    '{FUNC_DEC, 32'h55555555, 32'hAAAAAAAA},
    '{FUNC_ENC, 32'h01234567, 32'h89ABCDEF},
    '{FUNC_DEC, 32'h01234567, 32'h89ABCDEF},
    '{FUNC_ENC, 32'h7FFFFFFF, 32'h7FFFFFFF},
    '{FUNC_DEC, 32'h80000000, 32'h80000000}
  };

  xtea_block_cipher_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // One half-round: ((x<<4 ^ x>>5) + x) ^ (sum + key word)
  function automatic logic [31:0] round_mix(logic [31:0] x, logic [31:0] s,
                                            logic [31:0] kw);
    logic [31:0] t;
    t = ((x << 4) ^ (x >> 5)) + x;
    return t ^ (s + kw);
  endfunction

  // Full XTEA pass over one block in the selected direction
  function automatic xtea_pkg::out_beat_t xtea_transform(xtea_pkg::in_beat_t b,
                                                         xtea_pkg::key_t k);
    logic [31:0]         y;
    logic [31:0]         z;
    logic [31:0]         s;
    xtea_pkg::out_beat_t r;
    y = b.block_left;
    z = b.block_right;
    if (b.func == FUNC_ENC) begin
      s = 32'h0;
      for (int i = 0; i < ROUNDS; i++) begin
        y = y + round_mix(z, s, k[s[1:0]]);
        s = s + xtea_pkg::DELTA;
        z = z + round_mix(y, s, k[s[12:11]]);
      end
    end else begin
      s = xtea_pkg::DELTA * 32'(ROUNDS);
      for (int i = 0; i < ROUNDS; i++) begin
        z = z - round_mix(y, s, k[s[12:11]]);
        s = s - xtea_pkg::DELTA;
        y = y - round_mix(z, s, k[s[1:0]]);
      end
    end
    r.result_left  = y;
    r.result_right = z;
    return r;
  endfunction

  // Block half biased toward the corners of the 32-bit range
  function automatic logic [31:0] corner_word();
    case ($urandom_range(0, 5))
      0: return 32'h00000000;
      1: return 32'hFFFFFFFF;
      2: return 32'h80000000;
      3: return 32'h7FFFFFFF;
      4: return 32'h00000001;
      default: return $urandom();
    endcase
  endfunction

  // Offer one block, hold it until taken, then log its expected result
  task automatic send_block(xtea_pkg::in_beat_t b);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(xtea_transform(b, cur_key));
    if (b.func == FUNC_ENC) enc_blocks++;
    else dec_blocks++;
  endtask

  // One register write beat; indexes past the key words are dropped
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx < KEY_WORDS) cur_key[idx[1:0]] = val;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Main sequence: reset, directed blocks, then keyed random phases
  initial begin
    int                  n;
    logic [31:0]         kw;
    xtea_pkg::in_beat_t  b;
    xtea_pkg::in_beat_t  b2;
    xtea_pkg::out_beat_t ct;
    int                  pick;

    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    cur_key   = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    key_settings = 1;

    foreach (directed_rows[i]) send_block(directed_rows[i]);
    in_valid <= 1'b0;
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      calm = (p == NUM_PHASES - 1);

      // Load this phase's key, then poke unused indexes
      for (int w = 0; w < KEY_WORDS; w++) begin
        case (p)
          0: kw = 32'hFFFFFFFF;
          2: kw = (w == 0) ? 32'h80000000 : (w == 1) ? 32'h00000001 :
                  (w == 2) ? 32'h7FFFFFFF : 32'hFFFFFFFE;
          3: kw = 32'h00000000;
          default: kw = $urandom();
        endcase
        write_reg(key_regs[w], kw);
      end
      write_reg(IDX_W'(IDX_MAX), $urandom());
      write_reg(IDX_W'($urandom_range(KEY_WORDS, IDX_MAX)), $urandom());
      cfg_valid <= 1'b0;
      key_settings++;

      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
          b.func        = 1'($urandom_range(0, 1));
          b.block_left  = corner_word();
          b.block_right = corner_word();
          send_block(b);
          n++;
        end else if (pick < 5) begin
          // Encrypt a block, then decrypt its ciphertext
          b.func        = FUNC_ENC;
          b.block_left  = $urandom();
          b.block_right = $urandom();
          send_block(b);
          ct = xtea_transform(b, cur_key);
          b2.func        = FUNC_DEC;
          b2.block_left  = ct.result_left;
          b2.block_right = ct.result_right;
          send_block(b2);
          n += 2;
        end else begin
          b.func        = 1'($urandom_range(0, 1));
          b.block_left  = $urandom();
          b.block_right = $urandom();
          send_block(b);
          n++;
        end
      end
      in_valid <= 1'b0;
      wait_drained();
    end

    // Let any stray beat show up before closing
    repeat (LATENCY + 20) @(posedge clk);
    $display("summary: %0d blocks (%0d encrypt, %0d decrypt), %0d results checked",
             enc_blocks + dec_blocks, enc_blocks, dec_blocks, results_seen);
    $display("summary: %0d key settings incl. reset, one long output stall",
             key_settings);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Receiver: check each result beat, then pick next cycle's ready
  initial begin
    int                  stall_left;
    xtea_pkg::out_beat_t exp_beat;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected, got %h %h", $time,
                   out_data.result_left, out_data.result_right);
        end else begin
          exp_beat = pending_results.pop_front();
          if (out_data.result_left !== exp_beat.result_left) begin
            errors++;
            $display("%0t: result_left expected %h got %h", $time,
                     exp_beat.result_left, out_data.result_left);
          end
          if (out_data.result_right !== exp_beat.result_right) begin
            errors++;
            $display("%0t: result_right expected %h got %h", $time,
                     exp_beat.result_right, out_data.result_right);
          end
        end
      end

      // Hold off once for a long stretch so the pipeline backs up
      if (!pressure_done && results_seen >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        stall_left    = PRESSURE_HOLD;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(0, 9);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule
